// ===== hdl/ppr3d_pkg.sv =====
// Shared constants for the height-map point projection block.
`timescale 1ns / 1ps
`default_nettype none
package ppr3d_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_GRID_DIMS     = 3'd0;
  localparam logic [2:0] REG_Z_MIN         = 3'd1;
  localparam logic [2:0] REG_Z_MAX         = 3'd2;
  localparam logic [2:0] REG_Z_SCALE       = 3'd3;
  localparam logic [2:0] REG_ISO_MODE      = 3'd4;
  localparam logic [2:0] REG_ROTATION_TRIG = 3'd5;
  localparam logic [2:0] REG_VIEW_SCALE    = 3'd6;
  localparam logic [2:0] REG_VIEW_OFFSET   = 3'd7;

  localparam int unsigned CFG_INDEX_BITS = 3;
  localparam int unsigned CFG_DATA_BITS  = 64;

  // Q2.14 trig
  localparam int unsigned TRIG_FRAC = 14;
  localparam logic signed [15:0] ISO_COS = 16'sd14189;

  // Colour constants
  localparam logic [23:0] GREY      = 24'h282828;
  localparam logic [7:0]  CHAN_FULL = 8'hFF;

  localparam int unsigned OUT_BITS = 88;

endpackage
`default_nettype wire

// ===== hdl/point_projection_3d.sv =====
// Top level of the height-map point projection pipeline.
`timescale 1ns / 1ps
`default_nettype none
// An accepted input word passes through the registers of stages 1 to 6 in order.
// Throughput: one point per cycle; all six stages advance together whenever
// the output register is empty or the downstream side takes its word.
// The colour quotient is a restoring divider, two bits per stage.
// Reset (rst, synchronous) empties the pipeline and loads the register defaults.
module point_projection_3d #(
  parameter int COORD_BITS  = 10,
  parameter int HEIGHT_BITS = 16,
  parameter int FRAC_BITS   = 8
) (
  input  wire logic clk,
  input  wire logic rst,
  // Input stream
  input  wire logic s_tvalid,
  output logic      s_tready,
  // grid_x, grid_y, height_z (lowest bits first), zero padded to bytes
  input  wire logic [((2*COORD_BITS+HEIGHT_BITS+7)/8)*8-1:0] s_tdata,
  // Output stream
  output logic      m_tvalid,
  input  wire logic m_tready,
  // screen_x, screen_y, depth, pixel_color, range_error (lowest first), padded
  output logic [ppr3d_pkg::OUT_BITS-1:0] m_tdata,
  // Configuration write port
  input  wire logic cfg_wr_en,
  input  wire logic [ppr3d_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [ppr3d_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int C   = COORD_BITS;
  localparam int HB  = HEIGHT_BITS;
  localparam int F   = FRAC_BITS;
  localparam int GW  = 18;                         // centred grid, half units
  localparam int XW  = GW + F;
  localparam int DZW = (HB + 2 > 18) ? HB + 2 : 18; // centred height
  localparam int ZW  = DZW + 17;                   // scaled height
  localparam int VW  = ZW + 5;                     // view-space coordinates
  localparam int PW  = VW + 17;                    // trig product sums
  localparam int SW  = VW + 18;                    // screen products
  localparam int SH  = 2 * F + 1;
  localparam int NW  = (HB + 8 > 24) ? HB + 8 : 24; // divider remainder
  localparam int TS  = ppr3d_pkg::TRIG_FRAC;

  localparam logic signed [SW-1:0] RND_BIAS = (SW'(1) <<< SH) - SW'(1);
  localparam logic signed [SW-1:0] S16_MAX  = SW'(32767);
  localparam logic signed [SW-1:0] S16_MIN  = -SW'(32768);
  localparam logic signed [VW-1:0] D24_MAX  = VW'(8388607);
  localparam logic signed [VW-1:0] D24_MIN  = -VW'(8388608);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [31:0] grid_dims;
  logic [15:0] z_min;
  logic [15:0] z_max;
  logic [15:0] z_scale;
  logic        iso_mode;
  logic [63:0] rotation_trig;
  logic [15:0] view_scale;
  logic [31:0] view_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_dims     <= '0;
      z_min         <= '0;
      z_max         <= '0;
      z_scale       <= 16'd256;
      iso_mode      <= 1'b1;
      rotation_trig <= '0;
      view_scale    <= 16'd256;
      view_offset   <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        ppr3d_pkg::REG_GRID_DIMS:     grid_dims     <= cfg_data[31:0];
        ppr3d_pkg::REG_Z_MIN:         z_min         <= cfg_data[15:0];
        ppr3d_pkg::REG_Z_MAX:         z_max         <= cfg_data[15:0];
        ppr3d_pkg::REG_Z_SCALE:       z_scale       <= cfg_data[15:0];
        ppr3d_pkg::REG_ISO_MODE:      iso_mode      <= cfg_data[0];
        ppr3d_pkg::REG_ROTATION_TRIG: rotation_trig <= cfg_data;
        ppr3d_pkg::REG_VIEW_SCALE:    view_scale    <= cfg_data[15:0];
        ppr3d_pkg::REG_VIEW_OFFSET:   view_offset   <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // Register-derived; user changes configuration only while idle (unenforced)
  logic signed [16:0] z_range;
  logic signed [15:0] cos_y, sin_y, cos_x, sin_x;
  logic        [15:0] div_d;

  assign z_range = $signed({z_max[15], z_max}) - $signed({z_min[15], z_min});
  assign div_d   = z_range[15:0];
  assign cos_y   = $signed(rotation_trig[15:0]);
  assign sin_y   = $signed(rotation_trig[31:16]);
  assign cos_x   = $signed(rotation_trig[47:32]);
  assign sin_x   = $signed(rotation_trig[63:48]);

  // ---------------------------------------------------------------------------
  // Pipeline control: advance every stage together while the output can move
  // ---------------------------------------------------------------------------
  logic en;
  logic v1, v2, v3, v4, v5;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      v4       <= 1'b0;
      v5       <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      v1       <= s_tvalid;
      v2       <= v1;
      v3       <= v2;
      v4       <= v3;
      v5       <= v4;
      m_tvalid <= v5;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: centre grid and height, form the colour dividend
  // ---------------------------------------------------------------------------
  logic [C-1:0]           in_gx, in_gy;
  logic signed [HB-1:0]   in_hz;
  logic signed [GW-1:0]   xc, yc;
  logic signed [DZW-1:0]  hz_ext, z_sum, dz_c;
  logic [NW-1:0]          n_c, dsh8;

  assign in_gx  = s_tdata[C-1:0];
  assign in_gy  = s_tdata[2*C-1:C];
  assign in_hz  = $signed(s_tdata[2*C+HB-1:2*C]);
  assign xc     = $signed({{(GW-C-1){1'b0}}, in_gx, 1'b0})
                  - $signed({2'b00, grid_dims[15:0]}) + GW'(1);
  assign yc     = $signed({{(GW-C-1){1'b0}}, in_gy, 1'b0})
                  - $signed({2'b00, grid_dims[31:16]}) + GW'(1);
  assign hz_ext = DZW'(in_hz);
  assign z_sum  = DZW'($signed(z_min)) + DZW'($signed(z_max));
  assign dz_c   = (hz_ext <<< 1) - z_sum;
  // 255 * height, only used for positive heights
  assign n_c    = NW'({in_hz[HB-2:0], 8'h00}) - NW'(in_hz[HB-2:0]);
  assign dsh8   = NW'({div_d, 8'h00});

  logic signed [XW-1:0]  x1, y1;
  logic signed [DZW-1:0] dz1;
  logic [NW-1:0]         rem1;
  logic                  qsat1, grey1, neg1, err1;

  always_ff @(posedge clk) begin
    if (en) begin
      x1    <= {xc, {F{1'b0}}};
      y1    <= {yc, {F{1'b0}}};
      dz1   <= dz_c;
      rem1  <= n_c;
      qsat1 <= n_c >= dsh8;
      err1  <= z_range == 17'sd0;
      grey1 <= (z_range == 17'sd0) || in_hz[HB-1] || (in_hz == '0);
      neg1  <= z_range[16];
    end
  end

  // Restoring division step: compare against the shifted divisor, subtract
  function automatic logic [NW:0] div_step(input logic [NW-1:0] rem,
                                           input logic [NW-1:0] sub);
    logic ge;
    ge = rem >= sub;
    div_step = {ge, ge ? rem - sub : rem};
  endfunction

  // ---------------------------------------------------------------------------
  // Stage 2: height scale, first trig products, quotient bits 7 and 6
  // ---------------------------------------------------------------------------
  logic [NW:0] d7, d6;
  assign d7 = div_step(rem1, NW'({div_d, 7'd0}));
  assign d6 = div_step(d7[NW-1:0], NW'({div_d, 6'd0}));

  logic signed [ZW-1:0]    z2;
  logic signed [XW+16:0]   pvx2;
  logic signed [XW:0]      hsum2;
  logic signed [XW+15:0]   pa2, pb2;
  logic signed [XW-1:0]    y2;
  logic signed [DZW-1:0]   dz2;
  logic [NW-1:0]           rem2;
  logic [7:0]              q2;
  logic                    qsat2, grey2, neg2, err2;

  always_ff @(posedge clk) begin
    if (en) begin
      z2    <= dz1 * $signed({1'b0, z_scale});
      pvx2  <= (XW+1)'(x1 - y1) * ppr3d_pkg::ISO_COS;
      hsum2 <= ((XW+1)'(x1) + (XW+1)'(y1)) >>> 1;
      pa2   <= x1 * cos_y;
      pb2   <= x1 * sin_y;
      y2    <= y1;
      dz2   <= dz1;
      rem2  <= d6[NW-1:0];
      q2    <= {d7[NW], d6[NW], 6'd0};
      qsat2 <= qsat1;
      grey2 <= grey1;
      neg2  <= neg1;
      err2  <= err1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: y-axis rotation, isometric x; quotient bits 5 and 4
  // ---------------------------------------------------------------------------
  logic [NW:0] d5, d4;
  assign d5 = div_step(rem2, NW'({div_d, 5'd0}));
  assign d4 = div_step(d5[NW-1:0], NW'({div_d, 4'd0}));

  logic signed [PW-1:0] rx_sum, rt_sum;
  logic signed [VW-1:0] vx_iso;
  assign rx_sum = PW'(pa2) + PW'(z2 * sin_y);
  assign rt_sum = PW'(z2 * cos_y) - PW'(pb2);
  assign vx_iso = VW'(pvx2 >>> TS);

  logic signed [VW-1:0]  vx3, vyi3, t3;
  logic signed [XW-1:0]  y3;
  logic signed [DZW-1:0] dz3;
  logic [NW-1:0]         rem3;
  logic [7:0]            q3;
  logic                  qsat3, grey3, neg3, err3;

  always_ff @(posedge clk) begin
    if (en) begin
      vx3   <= iso_mode ? vx_iso : VW'(rx_sum >>> TS);
      vyi3  <= VW'(hsum2) - VW'(z2);
      t3    <= VW'(rt_sum >>> TS);
      y3    <= y2;
      dz3   <= dz2;
      rem3  <= d4[NW-1:0];
      q3    <= {q2[7:6], d5[NW], d4[NW], 4'd0};
      qsat3 <= qsat2;
      grey3 <= grey2;
      neg3  <= neg2;
      err3  <= err2;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: x-axis rotation, select projection; quotient bits 3 and 2
  // ---------------------------------------------------------------------------
  logic [NW:0] d3, d2;
  assign d3 = div_step(rem3, NW'({div_d, 3'd0}));
  assign d2 = div_step(d3[NW-1:0], NW'({div_d, 2'd0}));

  logic signed [PW-1:0] ry_sum, rz_sum;
  assign ry_sum = PW'(y3 * cos_x) - PW'(t3 * sin_x);
  assign rz_sum = PW'(y3 * sin_x) + PW'(t3 * cos_x);

  logic signed [VW-1:0] vx4, vy4, vz4;
  logic [NW-1:0]        rem4;
  logic [7:0]           q4;
  logic                 qsat4, grey4, neg4, err4;

  always_ff @(posedge clk) begin
    if (en) begin
      vx4   <= vx3;
      vy4   <= iso_mode ? vyi3 : VW'(ry_sum >>> TS);
      vz4   <= iso_mode ? (VW'(dz3) <<< F) : VW'(rz_sum >>> TS);
      rem4  <= d2[NW-1:0];
      q4    <= {q3[7:4], d3[NW], d2[NW], 2'd0};
      qsat4 <= qsat3;
      grey4 <= grey3;
      neg4  <= neg3;
      err4  <= err3;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: zoom and offset; quotient bits 1 and 0
  // ---------------------------------------------------------------------------
  logic [NW:0] d1, d0;
  assign d1 = div_step(rem4, NW'({div_d, 1'd0}));
  assign d0 = div_step(d1[NW-1:0], NW'(div_d));

  logic signed [SW-1:0] off_x, off_y;
  assign off_x = SW'($signed(view_offset[15:0])) <<< SH;
  assign off_y = SW'($signed(view_offset[31:16])) <<< SH;

  logic signed [SW-1:0] px5, py5;
  logic signed [VW-1:0] vz5;
  logic [7:0]           q5;
  logic                 qsat5, grey5, neg5, err5;

  always_ff @(posedge clk) begin
    if (en) begin
      px5   <= SW'(vx4 * $signed({1'b0, view_scale})) + off_x;
      py5   <= SW'(vy4 * $signed({1'b0, view_scale})) + off_y;
      vz5   <= vz4;
      q5    <= {q4[7:2], d1[NW], d0[NW]};
      qsat5 <= qsat4;
      grey5 <= grey4;
      neg5  <= neg4;
      err5  <= err4;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: truncate toward zero, saturate, assemble colour
  // ---------------------------------------------------------------------------
  logic signed [SW-1:0] sx_t, sy_t;
  logic signed [VW-1:0] dz_t;
  logic [15:0]          sx_o, sy_o;
  logic [23:0]          dp_o, col_o;
  logic [7:0]           chan;

  assign sx_t = (px5 + (px5[SW-1] ? RND_BIAS : SW'(0))) >>> SH;
  assign sy_t = (py5 + (py5[SW-1] ? RND_BIAS : SW'(0))) >>> SH;
  assign dz_t = (vz5 + (vz5[VW-1] ? VW'(1) : VW'(0))) >>> 1;

  always_comb begin
    if (sx_t > S16_MAX)      sx_o = 16'h7FFF;
    else if (sx_t < S16_MIN) sx_o = 16'h8000;
    else                     sx_o = sx_t[15:0];
    if (sy_t > S16_MAX)      sy_o = 16'h7FFF;
    else if (sy_t < S16_MIN) sy_o = 16'h8000;
    else                     sy_o = sy_t[15:0];
    if (dz_t > D24_MAX)      dp_o = 24'h7FFFFF;
    else if (dz_t < D24_MIN) dp_o = 24'h800000;
    else                     dp_o = dz_t[23:0];
    // Inverted range clamps to zero; a quotient past 255 holds at full scale
    if (neg5)       chan = 8'h00;
    else if (qsat5) chan = ppr3d_pkg::CHAN_FULL;
    else            chan = q5;
    col_o = grey5 ? ppr3d_pkg::GREY : {chan, chan, ppr3d_pkg::CHAN_FULL};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {7'd0, err5, col_o, dp_o, sy_o, sx_o};
    end
  end

endmodule
`default_nettype wire
